@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with a fixed message, disabled while in reset
`define ASSERT_CLK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// clocked assertion with a caller message, disabled while in reset
`define ASSERT_CLK_MSG(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

@@ rtl/rnm_pkg.sv @@
// constants and register codes of the range normalized momentum marker
`default_nettype none

package rnm_pkg;

	// field widths
	localparam int PRICE_W = 32;
	localparam int SUM_W   = 40;
	localparam int PROD_W  = 40;
	localparam int NUM_W   = 52;
	localparam int MARK_W  = 12;
	localparam int BARS_W  = 10;
	localparam int CFG_W   = 8;

	// register indexes
	localparam logic REG_LOOKBACK     = 1'b0;
	localparam logic REG_RANGE_PERIOD = 1'b1;

	// defaults and limits
	localparam logic [CFG_W-1:0]  DEFAULT_LOOKBACK = 8'd8;
	localparam logic [CFG_W-1:0]  DEFAULT_PERIOD   = 8'd14;
	localparam logic [MARK_W-1:0] Q8_TEN           = 12'd2560;
	localparam logic [BARS_W-1:0] BARS_MAX         = 10'd1023;

endpackage

`default_nettype wire

@@ rtl/range_normalized_momentum_marker.sv @@
// top level: bar history, running range sum and bit-serial marker division
//
// Usage
//   s_tvalid/s_tready/s_tdata carry one completed price bar per transaction.
//   m_tvalid/m_tready/m_tdata carry one marker per bar, 0..2560 in unsigned Q8.
//   cfg_we/cfg_index/cfg_data write lookback (index 0) or range_period
//   (index 1); every write clears the bar history. Write only while idle.
// Sequence
//   A bar passes the range sum update, a shift-add multiply by the period,
//   one bit a cycle, scaling and range check, restoring division, one
//   quotient bit a cycle, and the output load. With fewer than two earlier
//   bars or a zero range sum it goes from the sum update straight to a zero
//   marker; a saturated marker is loaded straight from the range check. One
//   bar is in work at a time and the input reopens the cycle after the load.
// Reset and stall
//   arst_n clears the control state, the pointers and the range sum; the
//   history memories are not cleared and never used before being written.
//   The marker sits in an output register; a new bar is taken while it waits,
//   and a finished bar holds in its last step until the register frees.
`default_nettype none

`include "assert_macros.svh"

module range_normalized_momentum_marker import rnm_pkg::*; #(
	parameter int HISTORY_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// bar input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // close_price, high_price, low_price
	// marker output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // marker_q8, zero padding
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int AW     = $clog2(HISTORY_DEPTH);
	localparam int MaxEff = (HISTORY_DEPTH - 1 > 255) ? 255 : HISTORY_DEPTH - 1;
	localparam logic [CFG_W-1:0] MAX_EFF = CFG_W'(MaxEff);
	localparam logic [AW-1:0]    DEPTH_A = AW'(HISTORY_DEPTH);
	localparam logic [AW-1:0]    LAST_A  = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_MUL,
		ST_SCALE,
		ST_PRE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    lookback_q;
	logic [CFG_W-1:0]    range_period_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AW-1:0]       wp_q;
	logic [BARS_W-1:0]   bars_q;
	logic                sub_old_q;
	logic                calc_q;
	logic [PRICE_W-1:0]  close_q;
	logic [PRICE_W-1:0]  rng_q;
	logic [PRICE_W-1:0]  diff_q;
	logic [CFG_W-1:0]    mul_q;
	logic [2:0]          mul_cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [NUM_W-1:0]    num_q;
	logic [SUM_W-1:0]    rem_q;
	logic [MARK_W-1:0]   low_q;
	logic [MARK_W-1:0]   quo_q;
	logic [3:0]          div_cnt_q;
	logic                sat_q;
	logic                out_valid_q;
	logic [MARK_W-1:0]   out_data_q;

	// history memories and their registered read ports
	logic [PRICE_W-1:0]  close_mem [HISTORY_DEPTH];
	logic [PRICE_W-1:0]  range_mem [HISTORY_DEPTH];
	logic [PRICE_W-1:0]  rd_close_q;
	logic [PRICE_W-1:0]  rd_range_q;

	logic                accept;
	logic [CFG_W-1:0]    period_eff;
	logic [CFG_W-1:0]    lookback_eff;
	logic [CFG_W-1:0]    back_k;
	logic [AW-1:0]       period_a;
	logic [AW-1:0]       back_a;
	logic [AW-1:0]       addr_range;
	logic [AW-1:0]       addr_close;
	logic [PRICE_W-1:0]  in_close;
	logic [PRICE_W-1:0]  in_high;
	logic [PRICE_W-1:0]  in_low;
	logic [PRICE_W-1:0]  in_rng;
	logic [SUM_W-1:0]    old_ext;
	logic [SUM_W-1:0]    sum_add;
	logic [SUM_W:0]      trial;
	logic                trial_ge;

	assign in_close = s_tdata[31:0];
	assign in_high  = s_tdata[63:32];
	assign in_low   = s_tdata[95:64];

	// input open only in the idle state, closed in reset and during a register write
	assign s_tready = arst_n && (state_q == ST_IDLE) && !cfg_we;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_data_q};

	// effective register values, clamped below the history depth and to 255
	always_comb begin
		period_eff   = (range_period_q <= 8'd1) ? DEFAULT_PERIOD : range_period_q;
		if (period_eff > MAX_EFF) period_eff = MAX_EFF;
		lookback_eff = (lookback_q == '0) ? DEFAULT_LOOKBACK : lookback_q;
		if (lookback_eff > MAX_EFF) lookback_eff = MAX_EFF;
		back_k = (bars_q < BARS_W'(lookback_eff)) ? bars_q[CFG_W-1:0] : lookback_eff;
	end

	// circular read addresses behind the write pointer
	always_comb begin
		period_a   = AW'(period_eff);
		back_a     = AW'(back_k);
		addr_range = (wp_q >= period_a) ? wp_q - period_a : wp_q + DEPTH_A - period_a;
		addr_close = (wp_q >= back_a) ? wp_q - back_a : wp_q + DEPTH_A - back_a;
	end

	// range of the incoming bar, zero for the first bar after a clear
	always_comb begin
		if (bars_q == '0) begin
			in_rng = '0;
		end else begin
			in_rng = (in_high >= in_low) ? in_high - in_low : in_low - in_high;
		end
	end

	// datapath helpers
	always_comb begin
		old_ext  = SUM_W'(rd_range_q);
		sum_add  = sum_q + SUM_W'(rng_q);
		trial    = {rem_q, low_q[MARK_W-1]};
		trial_ge = (trial >= {1'b0, sum_q});
	end

	// history memories
	always_ff @(posedge clk) begin
		if (accept) begin
			close_mem[wp_q] <= in_close;
			range_mem[wp_q] <= in_rng;
			rd_close_q      <= close_mem[addr_close];
			rd_range_q      <= range_mem[addr_range];
		end
	end

	// sequencer, bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lookback_q     <= DEFAULT_LOOKBACK;
			range_period_q <= DEFAULT_PERIOD;
			sum_q          <= '0;
			wp_q           <= '0;
			bars_q         <= '0;
			sub_old_q      <= 1'b0;
			calc_q         <= 1'b0;
			mul_cnt_q      <= '0;
			div_cnt_q      <= '0;
			sat_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_DONE) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						close_q   <= in_close;
						rng_q     <= in_rng;
						mul_q     <= period_eff;
						sub_old_q <= (bars_q >= BARS_W'(period_eff));
						calc_q    <= (bars_q >= BARS_W'(2));
						wp_q      <= (wp_q == LAST_A) ? '0 : wp_q + 1'b1;
						if (bars_q != BARS_MAX) bars_q <= bars_q + 1'b1;
						state_q   <= ST_SUB;
					end
				end
				// drop the bar leaving the window, form the close difference
				ST_SUB: begin
					if (sub_old_q) sum_q <= (sum_q >= old_ext) ? sum_q - old_ext : '0;
					diff_q  <= (close_q >= rd_close_q) ? close_q - rd_close_q
					                                   : rd_close_q - close_q;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q <= sum_add;
					if (calc_q && sum_add != '0) begin
						prod_q    <= '0;
						mul_cnt_q <= '0;
						state_q   <= ST_MUL;
					end else begin
						quo_q   <= '0;
						sat_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				// difference times period, one period bit a cycle
				ST_MUL: begin
					prod_q    <= {prod_q[PROD_W-2:0], 1'b0}
					             + (mul_q[CFG_W-1] ? PROD_W'(diff_q) : '0);
					mul_q     <= {mul_q[CFG_W-2:0], 1'b0};
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == 3'd7) state_q <= ST_SCALE;
				end
				// times 2560 as two shifted copies
				ST_SCALE: begin
					num_q   <= {1'b0, prod_q, 11'b0} + {3'b0, prod_q, 9'b0};
					state_q <= ST_PRE;
				end
				// quotient of 4096 or more saturates at once
				ST_PRE: begin
					if (num_q[NUM_W-1:MARK_W] >= sum_q) begin
						sat_q   <= 1'b1;
						quo_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						sat_q     <= 1'b0;
						rem_q     <= num_q[NUM_W-1:MARK_W];
						low_q     <= num_q[MARK_W-1:0];
						quo_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				// restoring division, one quotient bit a cycle
				ST_DIV: begin
					rem_q     <= trial_ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
					quo_q     <= {quo_q[MARK_W-2:0], trial_ge};
					low_q     <= {low_q[MARK_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 4'(MARK_W - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_data_q  <= (sat_q || quo_q > Q8_TEN) ? Q8_TEN : quo_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// register write clears the history
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOOKBACK:     lookback_q     <= cfg_data;
					REG_RANGE_PERIOD: range_period_q <= cfg_data;
				endcase
				sum_q  <= '0;
				wp_q   <= '0;
				bars_q <= '0;
			end
		end
	end

	// checks
	`ASSERT_CLK_MSG(a_marker_range, m_tvalid |-> (m_tdata[11:0] <= Q8_TEN),
		"marker above 2560")
	`ASSERT_CLK_MSG(a_rem_below_sum, (state_q == ST_DIV) |-> (rem_q < sum_q),
		"division remainder not below range sum")
	`ASSERT_CLK(a_bars_advance,
		(accept && !cfg_we && bars_q != BARS_MAX) |=> (bars_q == $past(bars_q) + 1'b1))
	`ASSERT_CLK(a_wp_in_range, wp_q <= LAST_A)

endmodule

`default_nettype wire
